@@ rtl/core/tlnes_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlnes_pkg
// Shared types and constants of the line numbering and escaping formatter.
// ----------------------------------------------------------------------------
package tlnes_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 2'd1;

    localparam logic [1:0] MODE_OFF = 2'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CTRL_SHIFT = 8'h40;

    // What the back end has to write for one input byte, apart from the number.
    typedef struct packed {
        logic       has_num;
        logic       m_prefix;
        logic       caret;
        logic       dollar;
        logic [7:0] ch;
    } tlnes_desc_t;

    localparam int DESC_W = $bits(tlnes_desc_t);

endpackage
`default_nettype wire

@@ rtl/core/tlnes_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlnes_if
// Valid/ready channels of the formatter: input bytes, output bytes, registers.
// ----------------------------------------------------------------------------
interface tlnes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       new_file;

    modport source (output valid, output in_byte, output new_file, input ready);
    modport sink   (input valid, input in_byte, input new_file, output ready);
endinterface

interface tlnes_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface tlnes_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/text_line_number_escape_stream_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_number_escape_stream_unit
// Line numbering and escaping text formatter, one output byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
// Input bytes arrive on in_stream with new_file set on the first byte of a
// file; each transfer produces a run of output bytes on out_stream, the last
// one carrying last_of_run. The user must write registers through cfg only
// while idle, which the block itself does not enforce: index 0 number_mode,
// index 1 show_nonprinting. The front end takes one byte per cycle while
// its four-entry queue has room. The back end writes one output byte per
// cycle while the receiver is ready; an input byte produces one output byte
// for plain text, up to NUMBER_DIGITS + 5 with numbering and escapes. The
// back end sets the sustained rate.
// An input byte passes through the queue, the back end's entry registers
// and the output register. When the receiver stalls, the output register
// holds its byte, the queue fills and in_stream.ready drops.
// Reset clears the queue, sets the line counter to one at line start and
// turns numbering and escaping off.
// ----------------------------------------------------------------------------
module text_line_number_escape_stream_unit #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlnes_in_if.sink    in_stream,
    tlnes_out_if.source out_stream,
    tlnes_cfg_if.sink   cfg
);
    import tlnes_pkg::*;

    localparam int BCD_W = 4 * NUMBER_DIGITS;
    localparam int Q_W   = DESC_W + BCD_W;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    tlnes_desc_t      push_desc;
    logic [BCD_W-1:0] push_bcd;
    logic [Q_W-1:0]   head;
    tlnes_desc_t      head_desc;
    logic [BCD_W-1:0] head_bcd;

    tlnes_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_stream(in_stream),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (push_desc),
        .q_bcd    (push_bcd)
    );

    tlnes_fifo #(
        .WIDTH(Q_W)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_data({push_desc, push_bcd}),
        .pop    (q_pop),
        .rd_data(head),
        .full   (q_full),
        .empty  (q_empty)
    );

    assign head_desc = head[Q_W-1:BCD_W];
    assign head_bcd  = head[BCD_W-1:0];

    tlnes_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_desc    (head_desc),
        .q_bcd     (head_bcd),
        .q_pop     (q_pop),
        .out_stream(out_stream)
    );

endmodule
`default_nettype wire

@@ rtl/core/tlnes_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlnes_front
// Accepts input bytes, keeps the line counter and classifies each byte.
// ----------------------------------------------------------------------------
module tlnes_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    tlnes_in_if.sink                       in_stream,
    tlnes_cfg_if.sink                      cfg,
    input  wire logic                      q_full,
    output logic                           q_push,
    output tlnes_pkg::tlnes_desc_t         q_desc,
    output logic [4*NUMBER_DIGITS-1:0]     q_bcd
);
    import tlnes_pkg::*;

    localparam int BCD_W = 4 * NUMBER_DIGITS;

    logic [1:0]       mode_reg;
    logic             show_reg;
    logic [BCD_W-1:0] count_reg, count_next;
    logic             start_reg, start_next;

    logic             accept;
    logic [BCD_W-1:0] eff_count;
    logic             eff_start;
    logic [7:0]       c;
    logic [7:0]       c7;
    logic             is_nl;
    logic             has_num;
    logic [NUMBER_DIGITS:0] lower_nine;
    logic [BCD_W-1:0] inc_count;

    assign cfg.ready       = 1'b1;
    assign in_stream.ready = !q_full;
    assign accept          = in_stream.valid && !q_full;

    assign c         = in_stream.in_byte;
    assign is_nl     = (c == CH_NL);
    assign eff_count = in_stream.new_file ? BCD_W'(1) : count_reg;
    assign eff_start = in_stream.new_file || start_reg;
    assign has_num   = eff_start && (mode_reg != MODE_OFF) && (!mode_reg[1] || !is_nl);
    assign c7        = c[7] ? {1'b0, c[6:0]} : c;

    // A digit steps when every digit below it is nine; all nines holds.
    always_comb
    begin
        lower_nine[0] = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            lower_nine[i+1] = lower_nine[i] && (eff_count[4*i +: 4] == 4'd9);
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (lower_nine[NUMBER_DIGITS] || !lower_nine[i])
                inc_count[4*i +: 4] = eff_count[4*i +: 4];
            else if (eff_count[4*i +: 4] == 4'd9)
                inc_count[4*i +: 4] = 4'd0;
            else
                inc_count[4*i +: 4] = eff_count[4*i +: 4] + 4'd1;
        end
    end

    always_comb
    begin
        q_desc          = '0;
        q_desc.has_num  = has_num;
        q_desc.ch       = c;
        if (is_nl)
        begin
            q_desc.dollar = show_reg;
        end
        else if (show_reg)
        begin
            q_desc.m_prefix = c[7];
            if (c7 < CTRL_LIMIT && c7 != CH_TAB)
            begin
                q_desc.caret = 1'b1;
                q_desc.ch    = c7 + CTRL_SHIFT;
            end
            else if (c7 == CH_DEL)
            begin
                q_desc.caret = 1'b1;
                q_desc.ch    = CH_QUEST;
            end
            else
            begin
                q_desc.ch = c7;
            end
        end
    end

    assign q_push = accept;
    assign q_bcd  = eff_count;

    always_comb
    begin
        count_next = count_reg;
        start_next = start_reg;
        if (accept)
        begin
            count_next = has_num ? inc_count : eff_count;
            start_next = is_nl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OFF;
            show_reg  <= 1'b0;
            count_reg <= BCD_W'(1);
            start_reg <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            start_reg <= start_next;
            if (cfg.valid)
            begin
                if (cfg.index == REG_NUMBER_MODE)
                    mode_reg <= cfg.data;
                else if (cfg.index == REG_SHOW_NONPRINTING)
                    show_reg <= cfg.data[0];
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tlnes_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlnes_fifo
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module tlnes_fifo #(
    parameter int WIDTH = 36
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  full,
    output logic                  empty
);
    import tlnes_pkg::*;

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tlnes_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlnes_back
// Expands each queued entry into its output bytes, one byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module tlnes_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire tlnes_pkg::tlnes_desc_t      q_desc,
    input  wire logic [4*NUMBER_DIGITS-1:0]  q_bcd,
    output logic                             q_pop,
    tlnes_out_if.source                      out_stream
);
    import tlnes_pkg::*;

    localparam int BCD_W = 4 * NUMBER_DIGITS;
    localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    typedef enum logic [2:0] {
        S_NUM,
        S_TAB,
        S_M,
        S_DASH,
        S_CARET,
        S_DOLLAR,
        S_CHAR
    } phase_t;

    logic             busy_reg, busy_next;
    phase_t           phase_reg, phase_next;
    logic [DIG_W-1:0] digit_reg, digit_next;
    logic             lead_reg, lead_next;
    tlnes_desc_t      cur_reg, cur_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic             adv;
    logic [3:0]       dig;
    logic             dig_lead;

    function automatic phase_t after_num(input tlnes_desc_t d);
        if (d.m_prefix)
            return S_M;
        else if (d.caret)
            return S_CARET;
        else if (d.dollar)
            return S_DOLLAR;
        else
            return S_CHAR;
    endfunction

    assign adv      = !out_valid_reg || out_stream.ready;
    assign dig      = bcd_reg[4*digit_reg +: 4];
    assign dig_lead = lead_reg && (dig == 4'd0) && (digit_reg != '0);

    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        digit_next     = digit_reg;
        lead_next      = lead_reg;
        cur_next       = cur_reg;
        bcd_next       = bcd_reg;
        out_valid_next = out_valid_reg && !out_stream.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;

        if (busy_reg && adv)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            unique case (phase_reg)
                S_NUM:
                begin
                    out_byte_next = dig_lead ? CH_SPACE : (CH_ZERO + {4'd0, dig});
                    lead_next     = dig_lead;
                    if (digit_reg == '0)
                        phase_next = S_TAB;
                    else
                        digit_next = digit_reg - 1'b1;
                end
                S_TAB:
                begin
                    out_byte_next = CH_TAB;
                    phase_next    = after_num(cur_reg);
                end
                S_M:
                begin
                    out_byte_next = CH_M;
                    phase_next    = S_DASH;
                end
                S_DASH:
                begin
                    out_byte_next = CH_DASH;
                    phase_next    = cur_reg.caret ? S_CARET : S_CHAR;
                end
                S_CARET:
                begin
                    out_byte_next = CH_CARET;
                    phase_next    = S_CHAR;
                end
                S_DOLLAR:
                begin
                    out_byte_next = CH_DOLLAR;
                    phase_next    = S_CHAR;
                end
                S_CHAR:
                begin
                    out_byte_next = cur_reg.ch;
                    out_last_next = 1'b1;
                    busy_next     = 1'b0;
                end
                default:
                begin
                    phase_next = S_CHAR;
                end
            endcase
        end

        // The next entry is loaded as soon as the current one has written its last byte.
        if (!q_empty && (!busy_reg || (adv && phase_reg == S_CHAR)))
        begin
            q_pop      = 1'b1;
            busy_next  = 1'b1;
            cur_next   = q_desc;
            bcd_next   = q_bcd;
            digit_next = DIG_W'(NUMBER_DIGITS - 1);
            lead_next  = 1'b1;
            phase_next = q_desc.has_num ? S_NUM : after_num(q_desc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= S_CHAR;
            digit_reg     <= '0;
            lead_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            digit_reg     <= digit_next;
            lead_reg      <= lead_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        bcd_reg      <= bcd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_stream.valid       = out_valid_reg;
    assign out_stream.out_byte    = out_byte_reg;
    assign out_stream.last_of_run = out_last_reg;

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_num_phase_has_num: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg == S_NUM) |-> cur_reg.has_num)
        else $error("number phase on an entry without a number");

    a_dash_after_m: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg == S_DASH) |-> cur_reg.m_prefix)
        else $error("dash phase without a high byte prefix");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && adv && phase_reg == S_CHAR) |=> (out_valid_reg && out_last_reg))
        else $error("final byte of a run not marked");

endmodule
`default_nettype wire
